/* rtl/core/gga_sentence_field_parser_defines.svh */
// ----------------------------------------------------------------------------
// GGA sentence field parser assertion macros
// Shared property wrappers for the parser. Build with NO_ASSERTIONS defined
// to leave every assertion out.
// ----------------------------------------------------------------------------
`ifndef GGA_SENTENCE_FIELD_PARSER_DEFINES_SVH
`define GGA_SENTENCE_FIELD_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define GGA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GGA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GGA_ASSERT_SAME(label, ante, cons, msg)
`define GGA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/core/gga_pkg.sv */
// ----------------------------------------------------------------------------
// GGA parser package
// Types, constants and small lookup tables shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gga_pkg;

   // Defaults for the top-level parameters.
   localparam int GGA_MAX_SENTENCE_BYTES_DEFAULT     = 128;
   localparam int GGA_MINUTE_FRACTION_DIGITS_DEFAULT = 6;

   // Sentence layout.
   localparam logic [3:0] SECTION_COUNT = 4'd10;
   localparam int         HEADER_BYTES  = 7;

   // Section numbers that carry a field.
   localparam logic [3:0] SEC_TIME    = 4'd1;
   localparam logic [3:0] SEC_LAT     = 4'd2;
   localparam logic [3:0] SEC_LAT_DIR = 4'd3;
   localparam logic [3:0] SEC_LON     = 4'd4;
   localparam logic [3:0] SEC_LON_DIR = 4'd5;
   localparam logic [3:0] SEC_FIX     = 4'd6;
   localparam logic [3:0] SEC_SATS    = 4'd7;
   localparam logic [3:0] SEC_ALT     = 4'd9;

   // Saturation limits.
   localparam logic [31:0] TIME_LIMIT   = 32'd86399999;
   localparam logic [31:0] ALT_LIMIT    = 32'd99999999;
   localparam logic [31:0] MINUTE_CAP   = 32'h03FF_FFFF;
   localparam logic [11:0] LON_DEG_CAP  = 12'd255;
   localparam logic [2:0]  MILLI_DIGITS = 3'd3;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NORTH = 8'h4E;
   localparam logic [7:0] CHAR_EAST  = 8'h45;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_HEADER = 2'd1,
      STATUS_SHORT  = 2'd2,
      STATUS_FEW    = 2'd3
   } gga_status_type;

   // Per-sentence parse state, apart from the byte position.
   typedef struct packed {
      logic [3:0]     section_index;
      logic [7:0]     section_length;
      gga_status_type outcome;
      logic           parsing_done;
      logic           point_seen;
      logic           scan_halted;
      logic           alt_negative;
      logic [2:0]     frac_count;
      logic [26:0]    time_acc;
      logic [6:0]     lat_deg;
      logic [25:0]    lat_min;
      logic [7:0]     lon_deg;
      logic [25:0]    lon_min;
      logic [1:0]     hemi_flags;
      logic [3:0]     fix_reg;
      logic [6:0]     sat_reg;
      logic [26:0]    alt_acc;
   } gga_state_type;

   // Expected header text, one character per position.
   function automatic logic [7:0] gga_head_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h47;
         3'd4:    ch = 8'h47;
         3'd5:    ch = 8'h41;
         default: ch = CHAR_COMMA;
      endcase
      return ch;
   endfunction

   // Minimum character count of each section, commas not counted.
   function automatic logic [7:0] gga_min_len(input logic [3:0] idx);
      logic [7:0] len;
      unique case (idx)
         4'd0:    len = 8'd6;
         4'd1:    len = 8'd9;
         4'd2:    len = 8'd9;
         4'd3:    len = 8'd1;
         4'd4:    len = 8'd9;
         4'd5:    len = 8'd1;
         4'd6:    len = 8'd1;
         4'd7:    len = 8'd1;
         4'd8:    len = 8'd0;
         4'd9:    len = 8'd1;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

   // Powers of ten up to ten million.
   function automatic logic [31:0] gga_pow10(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0: val = 32'd1;
         3'd1: val = 32'd10;
         3'd2: val = 32'd100;
         3'd3: val = 32'd1000;
         3'd4: val = 32'd10000;
         3'd5: val = 32'd100000;
         3'd6: val = 32'd1000000;
         3'd7: val = 32'd10000000;
      endcase
      return val;
   endfunction

   // Millisecond weight of each hhmmss digit place.
   function automatic logic [31:0] gga_hms_weight(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0:    val = 32'd36000000;
         3'd1:    val = 32'd3600000;
         3'd2:    val = 32'd600000;
         3'd3:    val = 32'd60000;
         3'd4:    val = 32'd10000;
         3'd5:    val = 32'd1000;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/core/gga_byte_step.sv */
// ----------------------------------------------------------------------------
// GGA byte step
// Next-state logic for one sentence byte: header check, section counting,
// length checks and the field accumulators, all in one combinational pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gga_byte_step
   import gga_pkg::*;
#(
   parameter int MAX_SENTENCE_BYTES     = GGA_MAX_SENTENCE_BYTES_DEFAULT,
   parameter int MINUTE_FRACTION_DIGITS = GGA_MINUTE_FRACTION_DIGITS_DEFAULT,
   localparam int POS_W = $clog2(MAX_SENTENCE_BYTES + 1)
) (
   input  logic [7:0]       byte_value,
   input  logic [POS_W-1:0] pos_cur,
   input  gga_state_type    st_cur,
   output logic [POS_W-1:0] pos_next,
   output gga_state_type    st_next
);

   // Minute scaling follows the number of kept fraction digits.
   localparam logic [2:0]  MIN_FD = 3'(MINUTE_FRACTION_DIGITS);
   localparam longint unsigned MIN_RAW =
      64'(60) * 64'(gga_pow10(MIN_FD)) - 64'(1);
   localparam logic [31:0] MIN_LIMIT =
      (MIN_RAW > 64'(MINUTE_CAP)) ? MINUTE_CAP : 32'(MIN_RAW);

   logic        digit_ok;
   logic [3:0]  digit;
   logic [7:0]  len;

   // Shared decimal scanner signals.
   logic [31:0] sc_acc;
   logic [31:0] sc_limit;
   logic [2:0]  sc_fd;
   logic        sc_whole_ok;
   logic [31:0] sc_whole_sum;
   logic [31:0] sc_frac_sum;
   logic [31:0] sc_acc_out;
   logic        sc_point_out;
   logic        sc_halted_out;
   logic [2:0]  sc_count_out;

   // Fixed-place paths.
   logic [31:0] hms_sum;
   logic [31:0] time_fixed;
   logic [11:0] lon_sum;

   assign digit_ok = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);
   assign digit    = digit_ok ? 4'(byte_value - CHAR_ZERO) : 4'd0;
   assign len      = st_cur.section_length;

   // Pick accumulator, fraction width and limit for the current section.
   always_comb begin
      unique case (st_cur.section_index)
         SEC_TIME: begin
            sc_acc      = 32'(st_cur.time_acc);
            sc_fd       = MILLI_DIGITS;
            sc_limit    = TIME_LIMIT;
            sc_whole_ok = 1'b0;
         end
         SEC_LAT: begin
            sc_acc      = 32'(st_cur.lat_min);
            sc_fd       = MIN_FD;
            sc_limit    = MIN_LIMIT;
            sc_whole_ok = 1'b1;
         end
         SEC_LON: begin
            sc_acc      = 32'(st_cur.lon_min);
            sc_fd       = MIN_FD;
            sc_limit    = MIN_LIMIT;
            sc_whole_ok = 1'b1;
         end
         SEC_ALT: begin
            sc_acc      = 32'(st_cur.alt_acc);
            sc_fd       = MILLI_DIGITS;
            sc_limit    = ALT_LIMIT;
            sc_whole_ok = 1'b1;
         end
         default: begin
            sc_acc      = 32'd0;
            sc_fd       = MILLI_DIGITS;
            sc_limit    = TIME_LIMIT;
            sc_whole_ok = 1'b0;
         end
      endcase
   end

   // Whole digits shift the value up one place; fraction digits add in at
   // their own place until the kept width is used up.
   assign sc_whole_sum = {sc_acc[28:0], 3'b000} + {sc_acc[30:0], 1'b0}
                         + 32'(digit) * gga_pow10(sc_fd);
   assign sc_frac_sum  = sc_acc
                         + 32'(digit) * gga_pow10(3'(sc_fd - 3'd1 - st_cur.frac_count));

   always_comb begin
      sc_acc_out    = sc_acc;
      sc_point_out  = st_cur.point_seen;
      sc_halted_out = st_cur.scan_halted;
      sc_count_out  = st_cur.frac_count;
      if (!st_cur.scan_halted) begin
         if (digit_ok) begin
            if (!st_cur.point_seen) begin
               if (sc_whole_ok) begin
                  sc_acc_out = (sc_whole_sum > sc_limit) ? sc_limit : sc_whole_sum;
               end else begin
                  sc_halted_out = 1'b1;
               end
            end else if (st_cur.frac_count < sc_fd) begin
               sc_acc_out   = (sc_frac_sum > sc_limit) ? sc_limit : sc_frac_sum;
               sc_count_out = st_cur.frac_count + 3'd1;
            end
         end else if ((byte_value == CHAR_POINT) && !st_cur.point_seen) begin
            sc_point_out = 1'b1;
         end else begin
            sc_halted_out = 1'b1;
         end
      end
   end

   // The hhmmss places add their fixed millisecond weight.
   assign hms_sum    = 32'(st_cur.time_acc) + 32'(digit) * gga_hms_weight(len[2:0]);
   assign time_fixed = (hms_sum > TIME_LIMIT) ? TIME_LIMIT : hms_sum;

   // Longitude degrees saturate at one byte.
   assign lon_sum = {st_cur.lon_deg, 3'b000} + {3'b000, st_cur.lon_deg, 1'b0}
                    + 12'(digit);

   // Byte handling: stop conditions, header, commas, then field characters.
   always_comb begin
      st_next  = st_cur;
      pos_next = pos_cur;
      if (!st_cur.parsing_done) begin
         if (pos_cur >= POS_W'(MAX_SENTENCE_BYTES)) begin
            st_next.parsing_done = 1'b1;
         end else begin
            pos_next = pos_cur + POS_W'(1);
            if ((pos_cur < POS_W'(HEADER_BYTES))
                && (byte_value != gga_head_char(pos_cur[2:0]))) begin
               st_next.outcome      = STATUS_HEADER;
               st_next.parsing_done = 1'b1;
            end else if (byte_value == CHAR_NUL) begin
               st_next.parsing_done = 1'b1;
            end else if (byte_value == CHAR_COMMA) begin
               if (len < gga_min_len(st_cur.section_index)) begin
                  st_next.outcome      = STATUS_SHORT;
                  st_next.parsing_done = 1'b1;
               end else begin
                  st_next.section_index  = st_cur.section_index + 4'd1;
                  st_next.section_length = 8'd0;
                  st_next.point_seen     = 1'b0;
                  st_next.scan_halted    = 1'b0;
                  st_next.frac_count     = 3'd0;
                  if (st_cur.section_index == SECTION_COUNT - 4'd1) begin
                     st_next.parsing_done = 1'b1;
                  end
               end
            end else begin
               // Field character of the current section.
               unique case (st_cur.section_index)
                  SEC_TIME: begin
                     if (len < 8'd6) begin
                        st_next.time_acc = 27'(time_fixed);
                     end else begin
                        st_next.time_acc    = 27'(sc_acc_out);
                        st_next.point_seen  = sc_point_out;
                        st_next.scan_halted = sc_halted_out;
                        st_next.frac_count  = sc_count_out;
                     end
                  end
                  SEC_LAT: begin
                     if (len < 8'd2) begin
                        st_next.lat_deg = 7'({st_cur.lat_deg, 3'b000}
                                          + {st_cur.lat_deg, 1'b0} + 10'(digit));
                     end else begin
                        st_next.lat_min     = 26'(sc_acc_out);
                        st_next.point_seen  = sc_point_out;
                        st_next.scan_halted = sc_halted_out;
                        st_next.frac_count  = sc_count_out;
                     end
                  end
                  SEC_LAT_DIR: begin
                     if ((len == 8'd0) && (byte_value != CHAR_NORTH)) begin
                        st_next.hemi_flags[0] = 1'b1;
                     end
                  end
                  SEC_LON: begin
                     if (len < 8'd3) begin
                        st_next.lon_deg = (lon_sum > LON_DEG_CAP) ? 8'(LON_DEG_CAP)
                                                                  : 8'(lon_sum);
                     end else begin
                        st_next.lon_min     = 26'(sc_acc_out);
                        st_next.point_seen  = sc_point_out;
                        st_next.scan_halted = sc_halted_out;
                        st_next.frac_count  = sc_count_out;
                     end
                  end
                  SEC_LON_DIR: begin
                     if ((len == 8'd0) && (byte_value != CHAR_EAST)) begin
                        st_next.hemi_flags[1] = 1'b1;
                     end
                  end
                  SEC_FIX: begin
                     if (len == 8'd0) begin
                        st_next.fix_reg = digit;
                     end
                  end
                  SEC_SATS: begin
                     if ((len < 8'd2) && !st_cur.scan_halted) begin
                        if (digit_ok) begin
                           st_next.sat_reg = 7'({st_cur.sat_reg, 3'b000}
                                             + {st_cur.sat_reg, 1'b0} + 10'(digit));
                        end else begin
                           st_next.scan_halted = 1'b1;
                        end
                     end
                  end
                  SEC_ALT: begin
                     if ((len == 8'd0)
                         && ((byte_value == CHAR_MINUS) || (byte_value == CHAR_PLUS))) begin
                        st_next.alt_negative = (byte_value == CHAR_MINUS);
                     end else begin
                        st_next.alt_acc     = 27'(sc_acc_out);
                        st_next.point_seen  = sc_point_out;
                        st_next.scan_halted = sc_halted_out;
                        st_next.frac_count  = sc_count_out;
                     end
                  end
                  default: begin
                  end
               endcase
               if (len < 8'd255) begin
                  st_next.section_length = len + 8'd1;
               end
            end
         end
      end
   end

endmodule

/* rtl/core/gga_sentence_field_parser.sv */
// ----------------------------------------------------------------------------
// GGA sentence field parser
// A result is registered: it loads as the end-marked byte leaves the input stage.
// Throughput: one byte per cycle unless stalled; the combinational byte step sets the pace.
// The input stalls only while a result waits and an end-marked byte is queued.
// Synchronous active-high reset clears all parse state; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gga_sentence_field_parser_defines.svh"

module gga_sentence_field_parser
   import gga_pkg::*;
#(
   parameter int MAX_SENTENCE_BYTES     = GGA_MAX_SENTENCE_BYTES_DEFAULT,
   parameter int MINUTE_FRACTION_DIGITS = GGA_MINUTE_FRACTION_DIGITS_DEFAULT,
   localparam int POS_W = $clog2(MAX_SENTENCE_BYTES + 1)
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_sentence_byte,
   input  logic               req_end_of_sentence,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [26:0]        rsp_time_ms,
   output logic signed [7:0]  rsp_lat_degrees,
   output logic [25:0]        rsp_lat_minutes_micro,
   output logic signed [8:0]  rsp_lon_degrees,
   output logic [25:0]        rsp_lon_minutes_micro,
   output logic [3:0]         rsp_fix_quality,
   output logic [6:0]         rsp_satellite_count,
   output logic signed [27:0] rsp_altitude_mm
);

   // Input stage.
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_eos_ff;
   logic              req_accept;
   logic              blocked;
   logic              step_fire;

   // Parse state.
   gga_state_type     st_ff, st_in, st_step;
   logic [POS_W-1:0]  pos_ff, pos_in, pos_step;

   // Result stage.
   logic              rsp_valid_ff, rsp_valid_in;
   gga_status_type    status_now;
   logic              load_result;
   logic [1:0]        rsp_status_ff;
   logic [26:0]       rsp_time_ff;
   logic [7:0]        rsp_lat_deg_ff;
   logic [25:0]       rsp_lat_min_ff;
   logic [8:0]        rsp_lon_deg_ff;
   logic [25:0]       rsp_lon_min_ff;
   logic [3:0]        rsp_fix_ff;
   logic [6:0]        rsp_sats_ff;
   logic [27:0]       rsp_alt_ff;

   // An end-marked beat cannot move on while the last result is still held.
   assign blocked    = in_valid_ff && in_eos_ff && rsp_valid_ff && rsp_stall;
   assign req_stall  = blocked;
   assign req_accept = req_valid && !req_stall;
   assign step_fire  = in_valid_ff && !blocked;
   assign in_valid_in = req_accept || (in_valid_ff && blocked);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_sentence_byte;
         in_eos_ff  <= req_end_of_sentence;
      end
   end

   // Byte step logic.
   gga_byte_step #(
      .MAX_SENTENCE_BYTES     (MAX_SENTENCE_BYTES),
      .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
   ) u_step (
      .byte_value (in_byte_ff),
      .pos_cur    (pos_ff),
      .st_cur     (st_ff),
      .pos_next   (pos_step),
      .st_next    (st_step)
   );

   // Parse state starts over after every result.
   always_comb begin
      st_in  = st_ff;
      pos_in = pos_ff;
      if (step_fire) begin
         if (in_eos_ff) begin
            st_in  = '0;
            pos_in = '0;
         end else begin
            st_in  = st_step;
            pos_in = pos_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '0;
         pos_ff <= '0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
      end
   end

   // Final status: first recorded error, then header length, then section count.
   always_comb begin
      priority if (st_step.outcome != STATUS_OK) begin
         status_now = st_step.outcome;
      end else if (pos_step < POS_W'(HEADER_BYTES)) begin
         status_now = STATUS_HEADER;
      end else if (st_step.section_index < SECTION_COUNT) begin
         status_now = STATUS_FEW;
      end else begin
         status_now = STATUS_OK;
      end
   end

   assign load_result = step_fire && in_eos_ff;

   always_comb begin
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result beat; every field but status is zero on an error.
   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_status_ff <= status_now;
         if (status_now == STATUS_OK) begin
            rsp_time_ff    <= st_step.time_acc;
            rsp_lat_deg_ff <= st_step.hemi_flags[0] ? (8'd0 - {1'b0, st_step.lat_deg})
                                                    : {1'b0, st_step.lat_deg};
            rsp_lat_min_ff <= st_step.lat_min;
            rsp_lon_deg_ff <= st_step.hemi_flags[1] ? (9'd0 - {1'b0, st_step.lon_deg})
                                                    : {1'b0, st_step.lon_deg};
            rsp_lon_min_ff <= st_step.lon_min;
            rsp_fix_ff     <= st_step.fix_reg;
            rsp_sats_ff    <= st_step.sat_reg;
            rsp_alt_ff     <= st_step.alt_negative ? (28'd0 - {1'b0, st_step.alt_acc})
                                                   : {1'b0, st_step.alt_acc};
         end else begin
            rsp_time_ff    <= '0;
            rsp_lat_deg_ff <= '0;
            rsp_lat_min_ff <= '0;
            rsp_lon_deg_ff <= '0;
            rsp_lon_min_ff <= '0;
            rsp_fix_ff     <= '0;
            rsp_sats_ff    <= '0;
            rsp_alt_ff     <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_time_ms           = rsp_time_ff;
   assign rsp_lat_degrees       = $signed(rsp_lat_deg_ff);
   assign rsp_lat_minutes_micro = rsp_lat_min_ff;
   assign rsp_lon_degrees       = $signed(rsp_lon_deg_ff);
   assign rsp_lon_minutes_micro = rsp_lon_min_ff;
   assign rsp_fix_quality       = rsp_fix_ff;
   assign rsp_satellite_count   = rsp_sats_ff;
   assign rsp_altitude_mm       = $signed(rsp_alt_ff);

   // Checks on the parse state and the result register.
   `GGA_ASSERT_SAME(a_section_bound, 1'b1, st_ff.section_index <= SECTION_COUNT, "section index past the last section")
   `GGA_ASSERT_SAME(a_done_at_last, st_ff.section_index == SECTION_COUNT, st_ff.parsing_done, "parsing continues after the last comma")
   `GGA_ASSERT_NEXT(a_restart, load_result, rsp_valid_ff && (pos_ff == '0) && (st_ff.section_index == 4'd0), "result taken without clearing the parse state")
   `GGA_ASSERT_SAME(a_error_zero, rsp_valid_ff && (rsp_status_ff != STATUS_OK), (rsp_time_ff == '0) && (rsp_sats_ff == '0) && (rsp_alt_ff == '0), "error result carries field data")

endmodule

/* test/gga_fix_check_pkg.sv */
// ----------------------------------------------------------------------------
// GGA fix checker package
// Expected-fix model and scoreboard for the GGA sentence field parser bench.
// Each accepted character beat is parsed here the way the block should parse
// it. Each result beat is compared field by field with the oldest expected fix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gga_fix_check_pkg;
   import gga_pkg::*;

   // Block configuration under test.
   localparam int unsigned PARSE_BYTE_LIMIT = 128;
   localparam int unsigned MINUTE_DIGITS    = 6;
   localparam int unsigned MINUTE_MAX       = 60 * (10 ** MINUTE_DIGITS) - 1;
   localparam int unsigned LON_DEG_MAX      = 255;
   localparam int unsigned MILLI_PLACES     = 3;

   // Header text "$GPGGA," and the minimum length of each section.
   localparam logic [7:0] HEAD_TEXT [7] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41,
                                            CHAR_COMMA};
   localparam int unsigned SECTION_MIN [10] = '{6, 9, 9, 1, 9, 1, 1, 1, 0, 1};
   localparam int unsigned TEN_POW [8] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                           10000000};
   localparam int unsigned HMS_WEIGHT [6] = '{36000000, 3600000, 600000, 60000, 10000,
                                              1000};

   // One result beat of the parser.
   typedef struct packed {
      gga_status_type     status;
      logic [26:0]        time_ms;
      logic signed [7:0]  lat_degrees;
      logic [25:0]        lat_minutes_micro;
      logic signed [8:0]  lon_degrees;
      logic [25:0]        lon_minutes_micro;
      logic [3:0]         fix_quality;
      logic [6:0]         satellite_count;
      logic signed [27:0] altitude_mm;
   } gga_fix_type;

   class gga_fix_checker;
      // Parse state of the sentence in flight.
      int unsigned    pos_count, sect_idx, sect_len, frac_cnt;
      gga_status_type outcome;
      bit             done, point_seen, halted, alt_neg, lat_south, lon_west;
      int unsigned    time_acc, lat_deg, lat_min, lon_deg, lon_min;
      int unsigned    fix_dig, sat_cnt, alt_acc;

      gga_fix_type    expected_fixes[$];
      int unsigned    mismatches, fixes_checked, parsed_chars;

      function new();
         clear_state();
         mismatches    = 0;
         fixes_checked = 0;
         parsed_chars  = 0;
      endfunction

      function void clear_state();
         pos_count  = 0;
         sect_idx   = 0;
         sect_len   = 0;
         frac_cnt   = 0;
         outcome    = STATUS_OK;
         done       = 1'b0;
         point_seen = 1'b0;
         halted     = 1'b0;
         alt_neg    = 1'b0;
         lat_south  = 1'b0;
         lon_west   = 1'b0;
         time_acc   = 0;
         lat_deg    = 0;
         lat_min    = 0;
         lon_deg    = 0;
         lon_min    = 0;
         fix_dig    = 0;
         sat_cnt    = 0;
         alt_acc    = 0;
      endfunction

      function bit is_digit(logic [7:0] ch);
         return ch >= CHAR_ZERO && ch <= CHAR_NINE;
      endfunction

      function int unsigned digit_val(logic [7:0] ch);
         return is_digit(ch) ? ch - CHAR_ZERO : 0;
      endfunction

      function int unsigned cap(int unsigned v, int unsigned limit);
         return (v > limit) ? limit : v;
      endfunction

      // A decimal number: whole digits, one point, then fraction digits up to
      // the given width. Any other character ends the number.
      function int unsigned scan_number(int unsigned acc, logic [7:0] ch, int unsigned fd,
                                        int unsigned limit, bit whole_ok);
         int unsigned d;
         if (halted)
            return acc;
         if (is_digit(ch)) begin
            d = ch - CHAR_ZERO;
            if (!point_seen) begin
               if (whole_ok)
                  acc = cap(acc * 10 + d * TEN_POW[fd], limit);
               else
                  halted = 1'b1;
            end else if (frac_cnt < fd) begin
               acc = cap(acc + d * TEN_POW[fd - 1 - frac_cnt], limit);
               frac_cnt++;
            end
         end else if (ch == CHAR_POINT && !point_seen) begin
            point_seen = 1'b1;
         end else begin
            halted = 1'b1;
         end
         return acc;
      endfunction

      // Character p of the current section goes into its field.
      function void field_char(logic [7:0] ch, int unsigned p);
         case (sect_idx)
            SEC_TIME: begin
               if (p < 6)
                  time_acc = cap(time_acc + digit_val(ch) * HMS_WEIGHT[p], TIME_LIMIT);
               else
                  time_acc = scan_number(time_acc, ch, MILLI_PLACES, TIME_LIMIT, 1'b0);
            end
            SEC_LAT: begin
               if (p < 2)
                  lat_deg = lat_deg * 10 + digit_val(ch);
               else
                  lat_min = scan_number(lat_min, ch, MINUTE_DIGITS, MINUTE_MAX, 1'b1);
            end
            SEC_LAT_DIR: begin
               if (p == 0 && ch != CHAR_NORTH)
                  lat_south = 1'b1;
            end
            SEC_LON: begin
               if (p < 3)
                  lon_deg = cap(lon_deg * 10 + digit_val(ch), LON_DEG_MAX);
               else
                  lon_min = scan_number(lon_min, ch, MINUTE_DIGITS, MINUTE_MAX, 1'b1);
            end
            SEC_LON_DIR: begin
               if (p == 0 && ch != CHAR_EAST)
                  lon_west = 1'b1;
            end
            SEC_FIX: begin
               if (p == 0)
                  fix_dig = digit_val(ch);
            end
            SEC_SATS: begin
               if (p < 2 && !halted) begin
                  if (is_digit(ch))
                     sat_cnt = sat_cnt * 10 + digit_val(ch);
                  else
                     halted = 1'b1;
               end
            end
            SEC_ALT: begin
               if (p == 0 && (ch == CHAR_MINUS || ch == CHAR_PLUS))
                  alt_neg = (ch == CHAR_MINUS);
               else
                  alt_acc = scan_number(alt_acc, ch, MILLI_PLACES, ALT_LIMIT, 1'b1);
            end
            default: ;
         endcase
      endfunction

      // Header check, section counting and the first error that stops parsing.
      function void take_char(logic [7:0] ch);
         int unsigned p;
         if (done)
            return;
         if (pos_count >= PARSE_BYTE_LIMIT) begin
            done = 1'b1;
            return;
         end
         p = pos_count;
         pos_count++;
         if (p < HEADER_BYTES && ch != HEAD_TEXT[p]) begin
            outcome = STATUS_HEADER;
            done    = 1'b1;
            return;
         end
         if (ch == CHAR_NUL) begin
            done = 1'b1;
            return;
         end
         if (ch == CHAR_COMMA) begin
            if (sect_len < SECTION_MIN[sect_idx % SECTION_COUNT]) begin
               outcome = STATUS_SHORT;
               done    = 1'b1;
               return;
            end
            sect_idx++;
            sect_len   = 0;
            point_seen = 1'b0;
            halted     = 1'b0;
            frac_cnt   = 0;
            if (sect_idx >= SECTION_COUNT)
               done = 1'b1;
            return;
         end
         field_char(ch, sect_len);
         if (sect_len < 255)
            sect_len++;
      endfunction

      // An accepted input beat; the end-marked beat yields one expected fix.
      function void note_char(logic [7:0] ch, logic eos);
         gga_status_type st;
         gga_fix_type    fix;
         if (!done)
            parsed_chars++;
         take_char(ch);
         if (!eos)
            return;
         st = outcome;
         if (st == STATUS_OK && pos_count < HEADER_BYTES)
            st = STATUS_HEADER;
         if (st == STATUS_OK && sect_idx < SECTION_COUNT)
            st = STATUS_FEW;
         fix        = '0;
         fix.status = st;
         if (st == STATUS_OK) begin
            fix.time_ms           = 27'(time_acc);
            fix.lat_degrees       = 8'(lat_south ? 0 - lat_deg : lat_deg);
            fix.lat_minutes_micro = 26'(lat_min);
            fix.lon_degrees       = 9'(lon_west ? 0 - lon_deg : lon_deg);
            fix.lon_minutes_micro = 26'(lon_min);
            fix.fix_quality       = 4'(fix_dig);
            fix.satellite_count   = 7'(sat_cnt);
            fix.altitude_mm       = 28'(alt_neg ? 0 - alt_acc : alt_acc);
         end
         expected_fixes.push_back(fix);
         clear_state();
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: fix %0d mismatch, %s", $time, fixes_checked, what);
         mismatches++;
      endtask

      // A result beat against the oldest expected fix.
      task check_fix(gga_fix_type got);
         gga_fix_type want;
         if (expected_fixes.size() == 0) begin
            report_mismatch($sformatf("result beat with no fix expected, status %0d",
                                      got.status));
            return;
         end
         want = expected_fixes.pop_front();
         fixes_checked++;
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.time_ms !== want.time_ms)
            report_mismatch($sformatf("time_ms %0d, expected %0d",
                                      got.time_ms, want.time_ms));
         if (got.lat_degrees !== want.lat_degrees)
            report_mismatch($sformatf("lat_degrees %0d, expected %0d",
                                      got.lat_degrees, want.lat_degrees));
         if (got.lat_minutes_micro !== want.lat_minutes_micro)
            report_mismatch($sformatf("lat_minutes_micro %0d, expected %0d",
                                      got.lat_minutes_micro, want.lat_minutes_micro));
         if (got.lon_degrees !== want.lon_degrees)
            report_mismatch($sformatf("lon_degrees %0d, expected %0d",
                                      got.lon_degrees, want.lon_degrees));
         if (got.lon_minutes_micro !== want.lon_minutes_micro)
            report_mismatch($sformatf("lon_minutes_micro %0d, expected %0d",
                                      got.lon_minutes_micro, want.lon_minutes_micro));
         if (got.fix_quality !== want.fix_quality)
            report_mismatch($sformatf("fix_quality %0d, expected %0d",
                                      got.fix_quality, want.fix_quality));
         if (got.satellite_count !== want.satellite_count)
            report_mismatch($sformatf("satellite_count %0d, expected %0d",
                                      got.satellite_count, want.satellite_count));
         if (got.altitude_mm !== want.altitude_mm)
            report_mismatch($sformatf("altitude_mm %0d, expected %0d",
                                      got.altitude_mm, want.altitude_mm));
      endtask
   endclass

endpackage

/* test/tb_gga_sentence_field_parser.sv */
// ----------------------------------------------------------------------------
// GGA sentence field parser testbench
// Streams directed and random GGA sentences into the parser one character
// beat at a time, with random gaps and receiver stalls, and checks every
// result beat against the fix predicted by the checker package.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gga_sentence_field_parser;
   import gga_pkg::*;
   import gga_fix_check_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD        = 300;
   localparam int RANDOM_BYTE_GOAL = 300;
   localparam int RANDOM_LINE_GOAL = 4;
   localparam int DRAIN_CYCLES     = 8;

   logic               clock               = 1'b0;
   logic               reset               = 1'b1;
   logic               req_valid           = 1'b0;
   logic               req_stall;
   logic [7:0]         req_sentence_byte   = 8'h00;
   logic               req_end_of_sentence = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall           = 1'b0;
   logic [1:0]         rsp_status;
   logic [26:0]        rsp_time_ms;
   logic signed [7:0]  rsp_lat_degrees;
   logic [25:0]        rsp_lat_minutes_micro;
   logic signed [8:0]  rsp_lon_degrees;
   logic [25:0]        rsp_lon_minutes_micro;
   logic [3:0]         rsp_fix_quality;
   logic [6:0]         rsp_satellite_count;
   logic signed [27:0] rsp_altitude_mm;

   gga_fix_checker fix_board;
   logic [7:0]     line_q[$];
   bit             steady             = 1'b0;
   bit             hold_request       = 1'b0;
   int             quiet_cycles       = 0;
   int             input_stall_cycles = 0;
   int             lines_sent         = 0;

   gga_sentence_field_parser #(
      .MAX_SENTENCE_BYTES     (PARSE_BYTE_LIMIT),
      .MINUTE_FRACTION_DIGITS (MINUTE_DIGITS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sentence_byte     (req_sentence_byte),
      .req_end_of_sentence   (req_end_of_sentence),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_time_ms           (rsp_time_ms),
      .rsp_lat_degrees       (rsp_lat_degrees),
      .rsp_lat_minutes_micro (rsp_lat_minutes_micro),
      .rsp_lon_degrees       (rsp_lon_degrees),
      .rsp_lon_minutes_micro (rsp_lon_minutes_micro),
      .rsp_fix_quality       (rsp_fix_quality),
      .rsp_satellite_count   (rsp_satellite_count),
      .rsp_altitude_mm       (rsp_altitude_mm)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_q.push_back(s[i]);
   endfunction

   function automatic void add_digits(input int n);
      repeat (n) line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
   endfunction

   // A well-formed sentence with random field contents.
   function automatic void build_fix_line();
      line_q.delete();
      add_text("$GPGGA,");
      if ($urandom_range(0, 9) == 0)
         add_digits(6);
      else
         add_text($sformatf("%02d%02d%02d", $urandom_range(0, 23), $urandom_range(0, 59),
                            $urandom_range(0, 59)));
      add_text(".");
      add_digits($urandom_range(2, 5));
      // Latitude and its hemisphere.
      add_text($sformatf(",%02d%02d.", $urandom_range(0, 90), $urandom_range(0, 59)));
      add_digits($urandom_range(4, 8));
      case ($urandom_range(0, 4))
         0, 1:    add_text(",N,");
         2, 3:    add_text(",S,");
         default: begin
            add_text(",");
            line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            add_text(",");
         end
      endcase
      // Longitude and its hemisphere.
      if ($urandom_range(0, 9) == 0)
         add_digits(5);
      else
         add_text($sformatf("%03d%02d", $urandom_range(0, 180), $urandom_range(0, 59)));
      add_text(".");
      add_digits($urandom_range(4, 8));
      case ($urandom_range(0, 4))
         0, 1:    add_text(",E,");
         2, 3:    add_text(",W,");
         default: begin
            add_text(",");
            line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            add_text(",");
         end
      endcase
      // Fix digit, satellite count and dilution.
      if ($urandom_range(0, 9) == 0)
         line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      else
         add_digits(1);
      add_text(",");
      case ($urandom_range(0, 3))
         0:       add_digits(1);
         1:       add_digits(2);
         2:       add_digits(3);
         default: begin
            add_digits(1);
            add_text("x");
         end
      endcase
      add_text(",");
      if ($urandom_range(0, 1))
         add_text($sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9)));
      add_text(",");
      // Altitude, sometimes long enough to run past the byte limit.
      case ($urandom_range(0, 2))
         0:       add_text("-");
         1:       add_text("+");
         default: ;
      endcase
      add_digits(($urandom_range(0, 49) == 0) ? 70 : $urandom_range(1, 5));
      if ($urandom_range(0, 2) != 0) begin
         add_text(".");
         add_digits($urandom_range(0, 4));
      end
      add_text(",M,46.9,M,,*");
      add_digits(2);
   endfunction

   // Break a sentence: one wrong byte, a cut, or an extra comma.
   function automatic void damage_line();
      int k;
      k = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 2))
         0:       line_q[k] = 8'($urandom_range(0, 255));
         1:       while (line_q.size() > k + 1) void'(line_q.pop_back());
         default: line_q.insert(k, CHAR_COMMA);
      endcase
   endfunction

   function automatic void build_noise_line();
      line_q.delete();
      if ($urandom_range(0, 1))
         add_text("$GPGGA,");
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // One input beat: optional gap, then hold the payload until it is taken.
   task automatic send_beat(input logic [7:0] ch, input logic eos);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_sentence_byte   <= ch;
      req_end_of_sentence <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fix_board.note_char(ch, eos);
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_q.size(); i++)
         send_beat(line_q[i], i == line_q.size() - 1);
      lines_sent++;
   endtask

   task automatic send_text(input string s);
      line_q.delete();
      add_text(s);
      send_line();
   endtask

   // Result side: check each accepted beat, then choose the next stall.
   initial begin
      int          stall_left;
      int          hold_left;
      int          n;
      bit          hold_used;
      gga_fix_type got;
      stall_left = 0;
      hold_left  = 0;
      hold_used  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status            = gga_status_type'(rsp_status);
            got.time_ms           = rsp_time_ms;
            got.lat_degrees       = rsp_lat_degrees;
            got.lat_minutes_micro = rsp_lat_minutes_micro;
            got.lon_degrees       = rsp_lon_degrees;
            got.lon_minutes_micro = rsp_lon_minutes_micro;
            got.fix_quality       = rsp_fix_quality;
            got.satellite_count   = rsp_satellite_count;
            got.altitude_mm       = rsp_altitude_mm;
            fix_board.check_fix(got);
         end
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            n = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            rsp_stall  <= (n != 0);
            stall_left = (n > 0) ? n - 1 : 0;
         end
      end
   end

   // Watchdog on cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if (req_valid && req_stall)
         input_stall_cycles <= input_stall_cycles + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles.", quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      int byte_goal;
      int line_goal;
      int pick;
      fix_board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Well-formed sentences: typical, all zero and south-west, top of range.
      send_text("$GPGGA,123519.00,4807.038000,N,01131.000000,E,1,08,0.9,545.4,M,46.9,M,,*47");
      send_text("$GPGGA,000000.000,0000.000000,S,00000.000000,W,0,00,,-0.001,M");
      send_text({"$GPGGA,235959.999,9959.9999999,N,17959.9999999,E,9,99,99.9,",
                 "+99999.999,M,,M,,*7F"});
      // Saturation everywhere, hemisphere letters that are neither N nor E.
      send_text({"$GPGGA,995999.9999,9999999999.9,X,999999999999.9,Y,Z,9X,1,",
                 "9999999999.9999,M"});
      // Non-digits in fixed places and numbers ended early.
      send_text("$GPGGA,1a2b3c.4d,ab12.34567,n,0x012.3456,e,7,5,,.5,");
      send_text("$GPGGA,1234567.89,4807.0380,N,01131.0000,E,1,1,0,-12a3.4,");
      send_text("$GPGGA,123519.00,4807.038000,N,01131.000000,E,1,08,0.9,M,");
      // Header errors and sentences too short for a header.
      send_text("$GPGSA,A,3,04,05,,09,12,,,,,,,,,,2.5,1.3,2.1*39");
      send_text("XGPGGA,123519.00,");
      send_text("$GP");
      send_text("$");
      send_text("$GPGGA,");
      // Sections too short, and a sentence that stops early.
      send_text("$GPGGA,12351.00,4807.038000,N,");
      send_text("$GPGGA,123519.00,4807.038000,,01131.000000,E,1,08,0.9,545.4,");
      send_text("$GPGGA,123519.00,4807.038000,N,01131.000000,");
      // A zero byte in a field and in the header.
      line_q.delete();
      add_text("$GPGGA,123519.00,4807.038000,N,01131");
      line_q.push_back(CHAR_NUL);
      add_text("000000,E,1,08,0.9,545.4,M");
      send_line();
      line_q.delete();
      add_text("$GP");
      line_q.push_back(CHAR_NUL);
      add_text("GA,123519.00,");
      send_line();
      // Byte limit reached inside the altitude, and reached only in the tail.
      line_q.delete();
      add_text("$GPGGA,123519.00,4807.038000,N,01131.000000,E,1,08,0.9,");
      add_digits(90);
      add_text(",M,");
      send_line();
      line_q.delete();
      add_text("$GPGGA,123519.00,4807.038000,N,01131.000000,E,1,08,0.9,545.4,M,");
      repeat (90) add_text("x");
      send_line();

      // Receiver holds off while short sentences pile up behind it.
      steady       = 1'b1;
      hold_request = 1'b1;
      repeat (6) send_text("$GP");

      // Random sentences: mostly well formed, some broken, some noise.
      byte_goal = fix_board.parsed_chars + RANDOM_BYTE_GOAL;
      line_goal = lines_sent + RANDOM_LINE_GOAL;
      while (fix_board.parsed_chars < byte_goal || lines_sent < line_goal) begin
         steady = ($urandom_range(0, 4) == 0);
         pick   = $urandom_range(0, 99);
         if (pick < 85)
            build_fix_line();
         else
            build_noise_line();
         if (pick >= 70 && pick < 85)
            damage_line();
         send_line();
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // Drain the remaining fixes, then watch a little longer.
      while (fix_board.expected_fixes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d sentences (%0d parsed characters); checked %0d result beats.",
               lines_sent, fix_board.parsed_chars, fix_board.fixes_checked);
      $display("Input was held back for %0d cycles; %0d mismatches found.",
               input_stall_cycles, fix_board.mismatches);
      if (fix_board.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gga_pkg.sv
rtl/core/gga_byte_step.sv
rtl/core/gga_sentence_field_parser.sv
test/gga_fix_check_pkg.sv
test/tb_gga_sentence_field_parser.sv
